// File: design/s2cd_pkg.sv
// Shared types, constants and the microcode program of the seconds-to-date converter.
// Used by the sequencer, the datapath and the top level; depends on nothing.
package s2cd_pkg;

    localparam int TS_W    = 32;
    localparam int PC_W    = 4;
    localparam int DAYS_W  = 16;
    localparam int YEAR_W  = 7;
    localparam int MON_W   = 4;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Division by multiplication: floor(n / d) = (n * R) >> S for every n a step can see.
    // The day step drops the seven low bits first, since 86400 = 128 * 675.
    localparam int DAY_PRESHIFT = 7;
    localparam int HOUR_IN_W    = 17;
    localparam int MIN_IN_W     = 12;
    localparam int SH_DAY       = 35;
    localparam int SH_HOUR      = 29;
    localparam int SH_MIN       = 18;
    localparam logic [MUL_B_W-1:0] RECIP_DAY     = 26'd50903317; // ceil(2^35 / 675)
    localparam logic [MUL_B_W-1:0] RECIP_HOUR    = 26'd149131;   // ceil(2^29 / 3600)
    localparam logic [MUL_B_W-1:0] RECIP_MIN     = 26'd4370;     // ceil(2^18 / 60)
    localparam logic [MUL_B_W-1:0] SECS_PER_DAY  = 26'd86400;
    localparam logic [MUL_B_W-1:0] SECS_PER_HOUR = 26'd3600;
    localparam logic [MUL_B_W-1:0] SECS_PER_MIN  = 26'd60;

    localparam logic [TS_W-1:0]   QUAD_DAYS      = 32'd1461;
    localparam logic [TS_W-1:0]   LEAP_YEAR_DAYS = 32'd366;
    localparam logic [TS_W-1:0]   YEAR_DAYS      = 32'd365;
    localparam logic [DAYS_W-1:0] DAYS_IN_RANGE  = 16'd36525;
    localparam logic [YEAR_W-1:0] YEAR_LAST      = 7'd99;
    localparam logic [MON_W-1:0]  MONTH_LAST     = 4'd11;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_QUO_DAY,
        UOP_REM_DAY,
        UOP_QUO_HOUR,
        UOP_REM_HOUR,
        UOP_QUO_MIN,
        UOP_SAVE_MS,
        UOP_SUB_QUAD,
        UOP_SUB_YEAR,
        UOP_SUB_MON,
        UOP_DONE
    } uop_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_GE,
        COND_OOR,
        COND_WAIT
    } cond_t;

    // Program addresses that are jump targets.
    localparam logic [PC_W-1:0] PC_START     = 4'd0;
    localparam logic [PC_W-1:0] PC_QUAD_LOOP = 4'd7;
    localparam logic [PC_W-1:0] PC_YEAR_LOOP = 4'd8;
    localparam logic [PC_W-1:0] PC_MON_LOOP  = 4'd9;
    localparam logic [PC_W-1:0] PC_DONE      = 4'd10;

    typedef struct packed {
        uop_t             uop;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        logic             start;
        uop_t             uop;
    } ctrl_t;

    typedef struct packed {
        logic ge;
        logic oor;
        logic out_busy;
    } status_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{UOP_QUO_DAY,  COND_NONE,   PC_START};
            4'd1:    w = '{UOP_REM_DAY,  COND_NONE,   PC_START};
            4'd2:    w = '{UOP_QUO_HOUR, COND_NONE,   PC_START};
            4'd3:    w = '{UOP_REM_HOUR, COND_NONE,   PC_START};
            4'd4:    w = '{UOP_QUO_MIN,  COND_NONE,   PC_START};
            4'd5:    w = '{UOP_SAVE_MS,  COND_NONE,   PC_START};
            4'd6:    w = '{UOP_NOP,      COND_OOR,    PC_DONE};
            4'd7:    w = '{UOP_SUB_QUAD, COND_GE,     PC_QUAD_LOOP};
            4'd8:    w = '{UOP_SUB_YEAR, COND_GE,     PC_YEAR_LOOP};
            4'd9:    w = '{UOP_SUB_MON,  COND_GE,     PC_MON_LOOP};
            4'd10:   w = '{UOP_DONE,     COND_WAIT,   PC_DONE};
            default: w = '{UOP_NOP,      COND_ALWAYS, PC_DONE};
        endcase
        return w;
    endfunction

    // Length of month idx (0 = January) in a leap or common year.
    function automatic logic [4:0] month_len(input logic leap, input logic [MON_W-1:0] idx);
        logic [4:0] len;
        case (idx)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: design/s2cd_if.sv
// Valid/ready channel interfaces for the timestamp input and the date result.
// Depends on nothing.
interface s2cd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink   (input valid, input timestamp, output ready);
endinterface

interface s2cd_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic       out_of_range;

    modport source (output valid, output second, output minute, output hour, output day,
                    output month, output year, output out_of_range, input ready);
    modport sink   (input valid, input second, input minute, input hour, input day,
                    input month, input year, input out_of_range, output ready);
endinterface

// File: design/s2cd_sequencer.sv
// Microcode sequencer: step counter, program ROM lookup and jump logic.
// Depends on s2cd_pkg.
module s2cd_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  s2cd_pkg::status_t  status,
    output s2cd_pkg::ctrl_t    ctrl
);

    logic                       busy_reg, busy_next;
    logic [s2cd_pkg::PC_W-1:0]  pc_reg, pc_next;
    s2cd_pkg::ucode_t           word;
    logic                       take;

    assign word     = s2cd_pkg::ucode_rom(pc_reg);
    assign in_ready = !busy_reg;

    always_comb
    begin
        case (word.cond)
            s2cd_pkg::COND_ALWAYS: take = 1'b1;
            s2cd_pkg::COND_GE:     take = status.ge;
            s2cd_pkg::COND_OOR:    take = status.oor;
            s2cd_pkg::COND_WAIT:   take = status.out_busy;
            default:               take = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next = 1'b1;
                pc_next   = s2cd_pkg::PC_START;
            end
        end
        else if (take)
        begin
            pc_next = word.target;
        end
        else if (word.uop == s2cd_pkg::UOP_DONE)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_comb
    begin
        ctrl.start = in_valid && !busy_reg;
        ctrl.uop   = busy_reg ? word.uop : s2cd_pkg::UOP_NOP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= s2cd_pkg::PC_START;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= s2cd_pkg::PC_DONE)
        else $error("sequencer left the program");

    a_start_enters_program: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !busy_reg |=> busy_reg && pc_reg == s2cd_pkg::PC_START)
        else $error("accepted timestamp did not start the program");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg == s2cd_pkg::PC_DONE && !status.out_busy |=> !busy_reg)
        else $error("sequencer did not finish after the result was written");

endmodule

// File: design/s2cd_datapath.sv
// Datapath: a shared multiplier, one shared compare-and-subtract unit, working registers and
// the result register. Depends on s2cd_pkg and the date channel interface in s2cd_if.sv.
module s2cd_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [s2cd_pkg::TS_W-1:0]  timestamp,
    input  s2cd_pkg::ctrl_t            ctrl,
    output s2cd_pkg::status_t          status,
    s2cd_out_if.source                 date
);

    logic [s2cd_pkg::TS_W-1:0]   acc_reg, acc_next;
    logic [s2cd_pkg::DAYS_W-1:0] quo_reg, quo_next;
    logic [s2cd_pkg::DAYS_W-1:0] days_reg, days_next;
    logic [5:0]                  sec_reg, sec_next;
    logic [5:0]                  min_reg, min_next;
    logic [4:0]                  hour_reg, hour_next;
    logic [s2cd_pkg::YEAR_W-1:0] yr_reg, yr_next;
    logic [s2cd_pkg::MON_W-1:0]  mon_reg, mon_next;
    logic                        oor_reg, oor_next;
    logic                        out_valid_reg, out_valid_next;
    logic [5:0]                  out_sec_reg, out_sec_next;
    logic [5:0]                  out_min_reg, out_min_next;
    logic [4:0]                  out_hour_reg, out_hour_next;
    logic [4:0]                  out_day_reg, out_day_next;
    logic [3:0]                  out_mon_reg, out_mon_next;
    logic [6:0]                  out_yr_reg, out_yr_next;
    logic                        out_oor_reg, out_oor_next;

    logic [s2cd_pkg::MUL_A_W-1:0] mul_a;
    logic [s2cd_pkg::MUL_B_W-1:0] mul_b;
    logic [s2cd_pkg::MUL_P_W-1:0] mul_p;
    logic [s2cd_pkg::TS_W-1:0]    sub_opnd;
    logic [s2cd_pkg::TS_W-1:0]    diff;
    logic                         guard;
    logic                         ge;
    logic                         leap;
    logic                         out_busy;
    logic                         out_load;

    assign leap     = (yr_reg[1:0] == 2'b00);
    assign out_busy = out_valid_reg && !date.ready;
    assign out_load = (ctrl.uop == s2cd_pkg::UOP_DONE) && !out_busy;

    // Shared multiplier: a reciprocal for each quotient, the divisor for each remainder.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.uop)
            s2cd_pkg::UOP_QUO_DAY:
            begin
                mul_a = acc_reg[s2cd_pkg::TS_W-1:s2cd_pkg::DAY_PRESHIFT];
                mul_b = s2cd_pkg::RECIP_DAY;
            end
            s2cd_pkg::UOP_REM_DAY:
            begin
                mul_a = {{(s2cd_pkg::MUL_A_W-s2cd_pkg::DAYS_W){1'b0}}, quo_reg};
                mul_b = s2cd_pkg::SECS_PER_DAY;
            end
            s2cd_pkg::UOP_QUO_HOUR:
            begin
                mul_a = {{(s2cd_pkg::MUL_A_W-s2cd_pkg::HOUR_IN_W){1'b0}},
                         acc_reg[s2cd_pkg::HOUR_IN_W-1:0]};
                mul_b = s2cd_pkg::RECIP_HOUR;
            end
            s2cd_pkg::UOP_REM_HOUR:
            begin
                mul_a = {{(s2cd_pkg::MUL_A_W-s2cd_pkg::DAYS_W){1'b0}}, quo_reg};
                mul_b = s2cd_pkg::SECS_PER_HOUR;
            end
            s2cd_pkg::UOP_QUO_MIN:
            begin
                mul_a = {{(s2cd_pkg::MUL_A_W-s2cd_pkg::MIN_IN_W){1'b0}},
                         acc_reg[s2cd_pkg::MIN_IN_W-1:0]};
                mul_b = s2cd_pkg::RECIP_MIN;
            end
            s2cd_pkg::UOP_SAVE_MS:
            begin
                mul_a = {{(s2cd_pkg::MUL_A_W-s2cd_pkg::DAYS_W){1'b0}}, quo_reg};
                mul_b = s2cd_pkg::SECS_PER_MIN;
            end
            default: ;
        endcase
        mul_p = {{s2cd_pkg::MUL_B_W{1'b0}}, mul_a} * {{s2cd_pkg::MUL_A_W{1'b0}}, mul_b};
    end

    // Shared subtractor: remainders, four-year blocks, years and months.
    always_comb
    begin
        sub_opnd = mul_p[s2cd_pkg::TS_W-1:0];
        guard    = 1'b1;
        case (ctrl.uop)
            s2cd_pkg::UOP_SUB_QUAD: sub_opnd = s2cd_pkg::QUAD_DAYS;
            s2cd_pkg::UOP_SUB_YEAR:
            begin
                sub_opnd = leap ? s2cd_pkg::LEAP_YEAR_DAYS : s2cd_pkg::YEAR_DAYS;
                guard    = yr_reg < s2cd_pkg::YEAR_LAST;
            end
            s2cd_pkg::UOP_SUB_MON:
            begin
                sub_opnd = {27'd0, s2cd_pkg::month_len(leap, mon_reg)};
                guard    = mon_reg < s2cd_pkg::MONTH_LAST;
            end
            default: ;
        endcase
        ge   = guard && (acc_reg >= sub_opnd);
        diff = acc_reg - sub_opnd;
    end

    always_comb
    begin
        status.ge       = ge;
        status.oor      = oor_reg;
        status.out_busy = out_busy;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        days_next = days_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        yr_next   = yr_reg;
        mon_next  = mon_reg;
        oor_next  = oor_reg;
        if (ctrl.start)
        begin
            acc_next = timestamp;
        end
        case (ctrl.uop)
            s2cd_pkg::UOP_QUO_DAY:
            begin
                quo_next = mul_p[s2cd_pkg::SH_DAY+s2cd_pkg::DAYS_W-1:s2cd_pkg::SH_DAY];
            end
            s2cd_pkg::UOP_REM_DAY:
            begin
                days_next = quo_reg;
                acc_next  = diff;
            end
            s2cd_pkg::UOP_QUO_HOUR:
            begin
                quo_next = mul_p[s2cd_pkg::SH_HOUR+s2cd_pkg::DAYS_W-1:s2cd_pkg::SH_HOUR];
            end
            s2cd_pkg::UOP_REM_HOUR:
            begin
                hour_next = quo_reg[4:0];
                acc_next  = diff;
            end
            s2cd_pkg::UOP_QUO_MIN:
            begin
                quo_next = mul_p[s2cd_pkg::SH_MIN+s2cd_pkg::DAYS_W-1:s2cd_pkg::SH_MIN];
            end
            s2cd_pkg::UOP_SAVE_MS:
            begin
                min_next = quo_reg[5:0];
                sec_next = diff[5:0];
                acc_next = {{(s2cd_pkg::TS_W-s2cd_pkg::DAYS_W){1'b0}}, days_reg};
                oor_next = days_reg >= s2cd_pkg::DAYS_IN_RANGE;
                yr_next  = '0;
                mon_next = '0;
            end
            s2cd_pkg::UOP_SUB_QUAD:
            begin
                if (ge)
                begin
                    acc_next = diff;
                    yr_next  = yr_reg + 7'd4;
                end
            end
            s2cd_pkg::UOP_SUB_YEAR:
            begin
                if (ge)
                begin
                    acc_next = diff;
                    yr_next  = yr_reg + 7'd1;
                end
            end
            s2cd_pkg::UOP_SUB_MON:
            begin
                if (ge)
                begin
                    acc_next = diff;
                    mon_next = mon_reg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    // Result register: a finished date waits here while the next timestamp is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_sec_next   = out_sec_reg;
        out_min_next   = out_min_reg;
        out_hour_next  = out_hour_reg;
        out_day_next   = out_day_reg;
        out_mon_next   = out_mon_reg;
        out_yr_next    = out_yr_reg;
        out_oor_next   = out_oor_reg;
        if (out_valid_reg && date.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_sec_next   = sec_reg;
            out_min_next   = min_reg;
            out_hour_next  = hour_reg;
            out_day_next   = oor_reg ? 5'd0 : acc_reg[4:0] + 5'd1;
            out_mon_next   = oor_reg ? 4'd0 : mon_reg + 4'd1;
            out_yr_next    = oor_reg ? 7'd0 : yr_reg;
            out_oor_next   = oor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        quo_reg      <= quo_next;
        days_reg     <= days_next;
        sec_reg      <= sec_next;
        min_reg      <= min_next;
        hour_reg     <= hour_next;
        yr_reg       <= yr_next;
        mon_reg      <= mon_next;
        oor_reg      <= oor_next;
        out_sec_reg  <= out_sec_next;
        out_min_reg  <= out_min_next;
        out_hour_reg <= out_hour_next;
        out_day_reg  <= out_day_next;
        out_mon_reg  <= out_mon_next;
        out_yr_reg   <= out_yr_next;
        out_oor_reg  <= out_oor_next;
    end

    assign date.valid        = out_valid_reg;
    assign date.second       = out_sec_reg;
    assign date.minute       = out_min_reg;
    assign date.hour         = out_hour_reg;
    assign date.day          = out_day_reg;
    assign date.month        = out_mon_reg;
    assign date.year         = out_yr_reg;
    assign date.out_of_range = out_oor_reg;

    a_time_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_sec_reg < 6'd60 && out_min_reg < 6'd60 && out_hour_reg < 5'd24)
        else $error("time of day out of range");

    a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_oor_reg |->
            out_mon_reg >= 4'd1 && out_mon_reg <= 4'd12 && out_day_reg >= 5'd1
            && out_yr_reg <= s2cd_pkg::YEAR_LAST)
        else $error("calendar date malformed");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_oor_reg |->
            out_day_reg == 5'd0 && out_mon_reg == 4'd0 && out_yr_reg == 7'd0)
        else $error("date fields not cleared past the covered range");

endmodule

// File: design/seconds_to_calendar_date.sv
// Converts a count of seconds since 2000-01-01 00:00:00 into second, minute, hour, day,
// month and year since 2000. One timestamp is taken per transfer on the stamp channel and one
// date leaves per transfer on the date channel. A small microcode program drives a shared
// multiplier and a single compare-and-subtract unit: the time of day is split off by three
// divisions (by 86400, 3600 and 60), each done as a multiplication by a fixed reciprocal for
// the quotient and a multiply-and-subtract for the remainder, then the day count is walked
// through four-year blocks of 1461 days, single years and months, one subtraction a cycle.
// Every year divisible by four is a leap year. A timestamp at or past 3155760000 seconds (the
// end of 2099) sets out_of_range and zeroes day, month and year; the time of day is still
// given. The time of day is split off first; an out-of-range timestamp then skips the walk,
// which otherwise runs through up to 24 four-year blocks, 3 years and 11 months. The next
// timestamp is taken in the cycle after a result is written, while that result may still
// wait in the output register for its transfer.
// Depends on s2cd_pkg, s2cd_if.sv, s2cd_sequencer and s2cd_datapath.
module seconds_to_calendar_date (
    input  logic        clk,
    input  logic        rst_n,
    s2cd_in_if.sink     stamp,
    s2cd_out_if.source  date
);

    s2cd_pkg::ctrl_t   ctrl;
    s2cd_pkg::status_t status;
    logic              seq_ready;

    // The sequencer owns the input handshake and steps through the program.
    s2cd_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stamp.valid),
        .in_ready (seq_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    assign stamp.ready = seq_ready;

    // The datapath captures the timestamp on the accepting cycle and holds the result register.
    s2cd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .timestamp (stamp.timestamp),
        .ctrl      (ctrl),
        .status    (status),
        .date      (date)
    );

endmodule

// File: test/s2cd_date_checker.sv
// Scoreboard for the seconds-to-date converter: it predicts the date for every accepted timestamp
// and compares it, field by field, with the date transfers.
// Depends on s2cd_if.sv only.
module s2cd_date_checker (
    input  logic clk,
    input  logic rst_n,
    s2cd_in_if   stamp,
    s2cd_out_if  date,
    output int   mismatches,
    output int   outstanding,
    output int   converted,
    output int   past_range
);

    localparam logic [31:0] SECONDS_PER_DAY   = 32'd86400;
    localparam logic [31:0] DAYS_THROUGH_2099 = 32'd36525;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic       out_of_range;
    } calendar_t;

    calendar_t expected_dates[$];
    int        err_cnt  = 0;
    int        done_cnt = 0;
    int        oor_cnt  = 0;

    function automatic calendar_t to_calendar(input logic [31:0] ts);
        calendar_t   d;
        logic [31:0] days_left;
        logic [31:0] span;
        int unsigned yr;
        int unsigned mi;
        d.second       = 6'(ts % 60);
        d.minute       = 6'((ts / 60) % 60);
        d.hour         = 5'((ts / 3600) % 24);
        d.day          = '0;
        d.month        = '0;
        d.year         = '0;
        d.out_of_range = 1'b0;
        days_left      = ts / SECONDS_PER_DAY;
        if (days_left >= DAYS_THROUGH_2099)
        begin
            d.out_of_range = 1'b1;
        end
        else
        begin
            // Peel off whole years; 2000 is a leap year and so is every fourth after it.
            yr   = 0;
            span = 32'd366;
            while (days_left >= span && yr < 99)
            begin
                days_left = days_left - span;
                yr++;
                span = (yr % 4 == 0) ? 32'd366 : 32'd365;
            end
            mi   = 0;
            span = MONTH_DAYS[0];
            while (days_left >= span && mi < 11)
            begin
                days_left = days_left - span;
                mi++;
                span = MONTH_DAYS[mi] + ((mi == 1 && yr % 4 == 0) ? 1 : 0);
            end
            d.year  = 7'(yr);
            d.month = 4'(mi + 1);
            d.day   = 5'(days_left + 1);
        end
        return d;
    endfunction

    function automatic int compare_date(input calendar_t want, input calendar_t got);
        int bad;
        bad = 0;
        if (got.second !== want.second)
        begin
            $error("second: expected %0d, got %0d", want.second, got.second);
            bad++;
        end
        if (got.minute !== want.minute)
        begin
            $error("minute: expected %0d, got %0d", want.minute, got.minute);
            bad++;
        end
        if (got.hour !== want.hour)
        begin
            $error("hour: expected %0d, got %0d", want.hour, got.hour);
            bad++;
        end
        if (got.day !== want.day)
        begin
            $error("day: expected %0d, got %0d", want.day, got.day);
            bad++;
        end
        if (got.month !== want.month)
        begin
            $error("month: expected %0d, got %0d", want.month, got.month);
            bad++;
        end
        if (got.year !== want.year)
        begin
            $error("year: expected %0d, got %0d", want.year, got.year);
            bad++;
        end
        if (got.out_of_range !== want.out_of_range)
        begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range, got.out_of_range);
            bad++;
        end
        return bad;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        calendar_t want;
        calendar_t got;
        if (!rst_n)
        begin
            expected_dates.delete();
        end
        else
        begin
            // Results are retired before new timestamps are queued: a date leaving in the
            // same cycle as a timestamp arrives can never belong to that timestamp.
            if (date.valid && date.ready)
            begin
                got = '{date.second, date.minute, date.hour, date.day, date.month, date.year,
                        date.out_of_range};
                if (expected_dates.size() == 0)
                begin
                    $error("date transfer with no timestamp waiting for it");
                    err_cnt++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    err_cnt += compare_date(want, got);
                    done_cnt++;
                    if (want.out_of_range)
                        oor_cnt++;
                end
            end
            if (stamp.valid && stamp.ready)
                expected_dates.push_back(to_calendar(stamp.timestamp));
        end
        mismatches  <= err_cnt;
        outstanding <= expected_dates.size();
        converted   <= done_cnt;
        past_range  <= oor_cnt;
    end

endmodule

// File: test/tb_seconds_to_calendar_date.sv
// Top of the seconds-to-date testbench: clock, reset, timestamp stimulus, result back-pressure,
// a stall watchdog and the verdict. Depends on s2cd_if.sv, seconds_to_calendar_date and
// s2cd_date_checker.
module tb_seconds_to_calendar_date;

    // Number of random timestamps after the directed ones.
    localparam int RANDOM_STAMPS = 1130;
    // The random stamps are grouped in blocks; every third block runs with no idling at all.
    localparam int BLOCK_LEN     = 100;
    // The limit lies well past the slowest conversion plus the largest sender gap and
    // receiver stall. Reaching it without any transfer means the block has hung.
    localparam int IDLE_LIMIT    = 1000;
    // Settling time after the last result, comfortably past the longest conversion.
    localparam int DRAIN_CYCLES  = 100;

    localparam logic [31:0] FIRST_PAST_2099 = 32'd3155760000;
    // Days before the first of each month in a common year.
    localparam int CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic no_idle = 1'b0;
    int   idle_cycles = 0;
    int   mismatches;
    int   outstanding;
    int   converted;
    int   past_range;

    s2cd_in_if  stamp_ch ();
    s2cd_out_if date_ch ();

    seconds_to_calendar_date DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .stamp (stamp_ch),
        .date  (date_ch)
    );

    s2cd_date_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .stamp       (stamp_ch),
        .date        (date_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .converted   (converted),
        .past_range  (past_range)
    );

    always #5 clk = ~clk;

    // Seconds since the epoch for a given calendar moment. The year is counted from 2000,
    // the month from 0 (January) and the day of the month from 1. Leap days of earlier
    // years are counted as (yr + 3) / 4, since 2000 itself is a leap year.
    function automatic logic [31:0] stamp_at(input int yr, input int mon, input int dom,
                                             input int hr, input int mn, input int sc);
        longint days;
        days = 365 * yr + (yr + 3) / 4 + CUM_DAYS[mon] + ((mon > 1 && yr % 4 == 0) ? 1 : 0)
               + dom - 1;
        return 32'(((days * 24 + hr) * 60 + mn) * 60 + sc);
    endfunction

    // Random timestamp. Most fall inside the covered century, a quarter land within 121
    // seconds of a month start (which also hits every year start and every leap day edge),
    // some lie past 2099 and the rest are raw 32-bit values so that every bit toggles.
    function automatic logic [31:0] random_stamp();
        int unsigned pick;
        logic [31:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return $urandom_range(32'd0, FIRST_PAST_2099 - 1);
        if (pick < 80)
        begin
            base = stamp_at($urandom_range(0, 99), $urandom_range(0, 11), 1, 0, 0, 0);
            if ($urandom_range(0, 1) == 0 || base < 32'd200)
                return base + $urandom_range(0, 120);
            return base - 1 - $urandom_range(0, 120);
        end
        if (pick < 90)
            return $urandom_range(FIRST_PAST_2099, 32'hFFFF_FFFF);
        return $urandom();
    endfunction

    // One timestamp transfer. Valid stays high from one transfer to the next when no gap
    // is drawn, so back-to-back stamps really arrive back to back.
    task automatic send_stamp(input logic [31:0] ts);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            stamp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stamp_ch.valid     <= 1'b1;
        stamp_ch.timestamp <= ts;
        do
            @(posedge clk);
        while (!stamp_ch.ready);
    endtask

    // Stop sending and wait until every accepted timestamp has produced its date. The first
    // edge lets the checker's count take in the transfer that has just happened.
    task automatic wait_for_drain();
        stamp_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Stimulus: directed corner cases, then random blocks with occasional full drains.
    initial
    begin
        logic [31:0] directed[$];
        stamp_ch.valid     <= 1'b0;
        stamp_ch.timestamp <= '0;
        directed = '{
            32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            stamp_at(0, 1, 28, 23, 59, 59),     // last second before the first leap day
            stamp_at(0, 1, 29, 0, 0, 0),        // February 29th, 2000
            stamp_at(0, 2, 1, 0, 0, 0),
            stamp_at(0, 11, 31, 23, 59, 59),    // end of the 366-day year 2000
            stamp_at(1, 0, 1, 0, 0, 0),
            stamp_at(1, 1, 28, 23, 59, 59),     // common-year February end
            stamp_at(1, 2, 1, 0, 0, 0),
            stamp_at(96, 1, 29, 12, 30, 45),    // last leap day of the century
            stamp_at(99, 0, 1, 0, 0, 0),
            stamp_at(99, 11, 31, 23, 59, 59),   // last covered second
            FIRST_PAST_2099,                    // first out-of-range second
            32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
            stamp_at(23, 5, 30, 23, 59, 59)
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_stamp(directed[i]);
        // The sender holds off here until the block has returned every date.
        wait_for_drain();

        for (int i = 0; i < RANDOM_STAMPS; i++)
        begin
            if (i % BLOCK_LEN == 0)
            begin
                no_idle = ((i / BLOCK_LEN) % 3 == 2);
                if ($urandom_range(0, 3) == 0)
                    wait_for_drain();
            end
            send_stamp(random_stamp());
        end
        no_idle = 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d timestamps, %0d of them beyond the end of 2099.",
                 converted, past_range);
        $display("Covered time-of-day limits, leap days, month and year rollovers, %s",
                 "the 2099 edge and raw 32-bit counts.");
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result side: before each date transfer, ready is held low for a random number of
    // cycles. When no stall is drawn, ready simply stays high into the next transfer.
    initial
    begin
        int stall;
        date_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                date_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            date_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(date_ch.valid && date_ch.ready));
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (stamp_ch.valid && stamp_ch.ready) || (date_ch.valid && date_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $error("no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: seconds_to_calendar_date.f
design/s2cd_pkg.sv
design/s2cd_if.sv
design/s2cd_sequencer.sv
design/s2cd_datapath.sv
design/seconds_to_calendar_date.sv
test/s2cd_date_checker.sv
test/tb_seconds_to_calendar_date.sv
